// File: rtl/core/nearest_pattern_search_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest pattern search block
// Shorthand for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PATTERN_SEARCH_TOP_MACROS_SVH
`define NEAREST_PATTERN_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define NPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define NPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define NPS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/nps_pkg.sv
// ----------------------------------------------------------------------------
// Nearest pattern search package
// Shared widths, score weights, reciprocal table, register codes and types.
// ----------------------------------------------------------------------------
package nps_pkg;

   localparam int PATTERN_DIGITS  = 64;
   localparam int DIGIT_BITS      = 4;
   localparam int LANE_DIGITS     = 16;
   localparam int DIGIT_LANES     = PATTERN_DIGITS / LANE_DIGITS;
   localparam int LANE_CNT_BITS   = $clog2(LANE_DIGITS + 1);
   localparam int MATCH_BITS      = $clog2(PATTERN_DIGITS + 1);
   localparam int DIGIT_SHIFT     = $clog2(PATTERN_DIGITS);

   localparam int MAX_PHONEMES    = 16;
   localparam int PHON_BITS       = 8;
   localparam int PCOUNT_BITS     = 5;

   localparam int INDEX_BITS      = 16;
   localparam int SCORE_BITS      = 17;
   localparam int WORD_BITS       = 64;

   localparam int DIGIT_WEIGHT    = 45875;
   localparam int PHON_WEIGHT     = 19661;
   localparam int DIGIT_TERM_BITS = 16;
   localparam int PHON_TERM_BITS  = 15;
   localparam int DIGIT_PROD_BITS = MATCH_BITS + DIGIT_TERM_BITS;

   // Reciprocal table: entry d holds ceil(PHON_WEIGHT * 2^RECIP_SHIFT / d),
   // so that (p * entry) >> RECIP_SHIFT is floor(PHON_WEIGHT * p / d).
   localparam int RECIP_SHIFT     = 16;
   localparam int RECIP_BITS      = 31;
   localparam int PHON_PROD_BITS  = PCOUNT_BITS + RECIP_BITS;
   localparam longint PHON_NUM    = longint'(PHON_WEIGHT) << RECIP_SHIFT;

   localparam logic [RECIP_BITS-1:0] PHON_RECIP [0:MAX_PHONEMES] = '{
      RECIP_BITS'(0),
      RECIP_BITS'((PHON_NUM + 0) / 1),
      RECIP_BITS'((PHON_NUM + 1) / 2),
      RECIP_BITS'((PHON_NUM + 2) / 3),
      RECIP_BITS'((PHON_NUM + 3) / 4),
      RECIP_BITS'((PHON_NUM + 4) / 5),
      RECIP_BITS'((PHON_NUM + 5) / 6),
      RECIP_BITS'((PHON_NUM + 6) / 7),
      RECIP_BITS'((PHON_NUM + 7) / 8),
      RECIP_BITS'((PHON_NUM + 8) / 9),
      RECIP_BITS'((PHON_NUM + 9) / 10),
      RECIP_BITS'((PHON_NUM + 10) / 11),
      RECIP_BITS'((PHON_NUM + 11) / 12),
      RECIP_BITS'((PHON_NUM + 12) / 13),
      RECIP_BITS'((PHON_NUM + 13) / 14),
      RECIP_BITS'((PHON_NUM + 14) / 15),
      RECIP_BITS'((PHON_NUM + 15) / 16)
   };

   // Configuration register indexes.
   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIGITS_A   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIGITS_B   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIGITS_C   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIGITS_D   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PHON_LO    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PHON_HI    = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PHON_COUNT = 3'd6;

   typedef struct packed {
      logic                   valid;
      logic                   last;
   } stage_ctrl_type;

   typedef struct packed {
      logic [PCOUNT_BITS-1:0] match;
      logic [PCOUNT_BITS-1:0] max_count;
   } phon_result_type;

   typedef logic [LANE_CNT_BITS-1:0] lane_count_type;

   // Clamp a phoneme count to the table range.
   function automatic logic [PCOUNT_BITS-1:0] sat_count(input logic [PCOUNT_BITS-1:0] c);
      logic [PCOUNT_BITS-1:0] r;
      r = (c > PCOUNT_BITS'(MAX_PHONEMES)) ? PCOUNT_BITS'(MAX_PHONEMES) : c;
      return r;
   endfunction

endpackage

// File: rtl/core/nps_digit_lane.sv
// ----------------------------------------------------------------------------
// Digit match lane
// Counts equal nibbles between one query word and one candidate word.
// ----------------------------------------------------------------------------
module nps_digit_lane (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [nps_pkg::WORD_BITS-1:0] query_word,
   input  logic [nps_pkg::WORD_BITS-1:0] cand_word,
   output nps_pkg::lane_count_type      count
);
   import nps_pkg::*;

   logic [LANE_DIGITS-1:0] eq;
   lane_count_type         count_ff;
   lane_count_type         count_in;

   always_comb begin
      for (int i = 0; i < LANE_DIGITS; i++) begin
         eq[i] = (query_word[DIGIT_BITS*i +: DIGIT_BITS] ==
                  cand_word[DIGIT_BITS*i +: DIGIT_BITS]);
      end
      count_in = LANE_CNT_BITS'($countones(eq));
   end

   // Hold while the pipeline stalls.
   always_ff @(posedge clock) begin
      if (advance) begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

// File: rtl/core/nps_phon_lane.sv
// ----------------------------------------------------------------------------
// Phoneme match lane
// Counts equal phonemes over the shorter list and registers the longer count.
// ----------------------------------------------------------------------------
module nps_phon_lane (
   input  logic                            clock,
   input  logic                            advance,
   input  logic [2*nps_pkg::WORD_BITS-1:0] query_phon,
   input  logic [nps_pkg::PCOUNT_BITS-1:0] query_count,
   input  logic [2*nps_pkg::WORD_BITS-1:0] cand_phon,
   input  logic [nps_pkg::PCOUNT_BITS-1:0] cand_count,
   output nps_pkg::phon_result_type        result
);
   import nps_pkg::*;

   logic [PCOUNT_BITS-1:0]  cc;
   logic [PCOUNT_BITS-1:0]  min_count;
   logic [MAX_PHONEMES-1:0] eq;
   phon_result_type         result_ff;
   phon_result_type         result_in;

   always_comb begin
      cc        = sat_count(cand_count);
      min_count = (cc < query_count) ? cc : query_count;
      for (int i = 0; i < MAX_PHONEMES; i++) begin
         eq[i] = (PCOUNT_BITS'(i) < min_count) &&
                 (query_phon[PHON_BITS*i +: PHON_BITS] == cand_phon[PHON_BITS*i +: PHON_BITS]);
      end
      result_in.match     = PCOUNT_BITS'($countones(eq));
      result_in.max_count = (cc > query_count) ? cc : query_count;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: rtl/core/nps_merge.sv
// ----------------------------------------------------------------------------
// Lane merge and best-candidate tracker
// Sums lane counts into a score, then keeps the first highest-scoring index.
// ----------------------------------------------------------------------------
module nps_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  nps_pkg::stage_ctrl_type             s1_ctrl,
   input  nps_pkg::lane_count_type             lane_count [nps_pkg::DIGIT_LANES],
   input  nps_pkg::phon_result_type            phon,
   output logic                                rsp_valid,
   output logic [nps_pkg::INDEX_BITS-1:0]      rsp_best_index,
   output logic [nps_pkg::SCORE_BITS-1:0]      rsp_best_score,
   output logic                                rsp_index_overflow
);
   import nps_pkg::*;

   // Scoring stage
   logic [MATCH_BITS-1:0]      m_sum;
   logic [DIGIT_PROD_BITS-1:0] digit_prod;
   logic [PHON_PROD_BITS-1:0]  phon_prod;
   logic [SCORE_BITS-1:0]      score_in;
   logic [SCORE_BITS-1:0]      score_ff;
   stage_ctrl_type             s2_ctrl_ff;

   always_comb begin
      m_sum = '0;
      for (int l = 0; l < DIGIT_LANES; l++) begin
         m_sum = m_sum + MATCH_BITS'(lane_count[l]);
      end
      digit_prod = DIGIT_PROD_BITS'(m_sum) * DIGIT_PROD_BITS'(DIGIT_WEIGHT);
      phon_prod  = PHON_PROD_BITS'(phon.match) * PHON_PROD_BITS'(PHON_RECIP[phon.max_count]);
      score_in   = SCORE_BITS'(DIGIT_TERM_BITS'(digit_prod >> DIGIT_SHIFT)) +
                   SCORE_BITS'(PHON_TERM_BITS'(phon_prod >> RECIP_SHIFT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
      end else if (advance) begin
         s2_ctrl_ff <= s1_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         score_ff <= score_in;
      end
   end

   // Update stage
   logic                  seen_ff,  seen_in;
   logic                  ovf_ff,   ovf_in;
   logic [INDEX_BITS-1:0] cand_ff,  cand_in;
   logic [INDEX_BITS-1:0] bidx_ff,  bidx_in;
   logic [SCORE_BITS-1:0] bscore_ff, bscore_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [SCORE_BITS-1:0] rsp_score_ff, rsp_score_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;
   logic                  idx_sat;
   logic [INDEX_BITS-1:0] idx;
   logic                  take;

   always_comb begin
      idx_sat = seen_ff && (cand_ff == {INDEX_BITS{1'b1}});
      if (!seen_ff) begin
         idx = '0;
      end else if (idx_sat) begin
         idx = cand_ff;
      end else begin
         idx = cand_ff + INDEX_BITS'(1);
      end
      take = !seen_ff || (score_ff > bscore_ff);

      seen_in      = seen_ff;
      ovf_in       = ovf_ff;
      cand_in      = cand_ff;
      bidx_in      = bidx_ff;
      bscore_in    = bscore_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_score_in = rsp_score_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (advance) begin
         rsp_valid_in = 1'b0;
         if (s2_ctrl_ff.valid) begin
            seen_in   = 1'b1;
            ovf_in    = ovf_ff | idx_sat;
            cand_in   = idx;
            if (take) begin
               bidx_in   = idx;
               bscore_in = score_ff;
            end
            if (s2_ctrl_ff.last) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = bidx_in;
               rsp_score_in = bscore_in;
               rsp_ovf_in   = ovf_in;
               seen_in      = 1'b0;
               ovf_in       = 1'b0;
               cand_in      = '0;
               bidx_in      = '0;
               bscore_in    = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         cand_ff      <= '0;
         bidx_ff      <= '0;
         bscore_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         ovf_ff       <= ovf_in;
         cand_ff      <= cand_in;
         bidx_ff      <= bidx_in;
         bscore_ff    <= bscore_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_score_ff <= rsp_score_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_best_index     = rsp_index_ff;
   assign rsp_best_score     = rsp_score_ff;
   assign rsp_index_overflow = rsp_ovf_ff;

endmodule

// File: rtl/core/nearest_pattern_search_top.sv
// ----------------------------------------------------------------------------
// Nearest pattern search, top level
// Scores streamed candidates against a configured query and reports the best.
// ----------------------------------------------------------------------------
// Usage:
//   Load the query over the csr_ port (digit words, phoneme words, phoneme
//   count) while the block is idle. Then stream candidates on the req_
//   channel, one whole candidate per item, with req_last_candidate set on
//   the final one of a set. On that item's result the rsp_ channel carries
//   the first index with the highest score, that score in Q1.16 and the
//   index overflow flag; other items give no result.
//   Throughput: one item per cycle while no result is stalled. The last item's
//   result passes three register stages (match lanes, score multipliers,
//   compare-update), and the edge that accepts the item loads the first.
//   Reset clears the query, the tracker state and all stage valids.
//   When a result waits and rsp_ready is low, every stage holds and
//   req_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module nearest_pattern_search_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [nps_pkg::WORD_BITS-1:0]      req_cand_digits_a,
   input  logic [nps_pkg::WORD_BITS-1:0]      req_cand_digits_b,
   input  logic [nps_pkg::WORD_BITS-1:0]      req_cand_digits_c,
   input  logic [nps_pkg::WORD_BITS-1:0]      req_cand_digits_d,
   input  logic [nps_pkg::WORD_BITS-1:0]      req_cand_phon_lo,
   input  logic [nps_pkg::WORD_BITS-1:0]      req_cand_phon_hi,
   input  logic [nps_pkg::PCOUNT_BITS-1:0]    req_cand_phon_count,
   input  logic                               req_last_candidate,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [nps_pkg::INDEX_BITS-1:0]     rsp_best_index,
   output logic [nps_pkg::SCORE_BITS-1:0]     rsp_best_score,
   output logic                               rsp_index_overflow,
   input  logic                               csr_wr_en,
   input  logic [nps_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [nps_pkg::WORD_BITS-1:0]      csr_wdata
);
   import nps_pkg::*;

   // Query registers
   logic [WORD_BITS-1:0]   qdig_ff [DIGIT_LANES];
   logic [WORD_BITS-1:0]   qphon_lo_ff;
   logic [WORD_BITS-1:0]   qphon_hi_ff;
   logic [PCOUNT_BITS-1:0] qcount_ff;

   // Take a write at once; drop unknown indexes; clamp the phoneme count.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < DIGIT_LANES; l++) begin
            qdig_ff[l] <= '0;
         end
         qphon_lo_ff <= '0;
         qphon_hi_ff <= '0;
         qcount_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DIGITS_A:   qdig_ff[0]  <= csr_wdata;
            CSR_DIGITS_B:   qdig_ff[1]  <= csr_wdata;
            CSR_DIGITS_C:   qdig_ff[2]  <= csr_wdata;
            CSR_DIGITS_D:   qdig_ff[3]  <= csr_wdata;
            CSR_PHON_LO:    qphon_lo_ff <= csr_wdata;
            CSR_PHON_HI:    qphon_hi_ff <= csr_wdata;
            CSR_PHON_COUNT: qcount_ff   <= sat_count(csr_wdata[PCOUNT_BITS-1:0]);
            default: begin
            end
         endcase
      end
   end

   // Advance the whole pipeline unless a finished result is stalled.
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Stage 1 control: an item enters whenever the pipeline advances.
   stage_ctrl_type s1_ctrl_ff;
   stage_ctrl_type s1_ctrl_in;

   always_comb begin
      s1_ctrl_in.valid = req_valid;
      s1_ctrl_in.last  = req_last_candidate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
      end else if (advance) begin
         s1_ctrl_ff <= s1_ctrl_in;
      end
   end

   // Digit lanes, one per 16-digit word, side by side.
   logic [WORD_BITS-1:0] cand_dig [DIGIT_LANES];
   lane_count_type       lane_count [DIGIT_LANES];

   assign cand_dig[0] = req_cand_digits_a;
   assign cand_dig[1] = req_cand_digits_b;
   assign cand_dig[2] = req_cand_digits_c;
   assign cand_dig[3] = req_cand_digits_d;

   for (genvar l = 0; l < DIGIT_LANES; l++) begin : g_lane
      nps_digit_lane u_lane (
         .clock      (clock),
         .advance    (advance),
         .query_word (qdig_ff[l]),
         .cand_word  (cand_dig[l]),
         .count      (lane_count[l])
      );
   end

   // Phoneme lane
   phon_result_type phon;

   nps_phon_lane u_phon (
      .clock       (clock),
      .advance     (advance),
      .query_phon  ({qphon_hi_ff, qphon_lo_ff}),
      .query_count (qcount_ff),
      .cand_phon   ({req_cand_phon_hi, req_cand_phon_lo}),
      .cand_count  (req_cand_phon_count),
      .result      (phon)
   );

   // Merge lanes into a score and track the best candidate.
   nps_merge u_merge (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .s1_ctrl            (s1_ctrl_ff),
      .lane_count         (lane_count),
      .phon               (phon),
      .rsp_valid          (rsp_valid),
      .rsp_best_index     (rsp_best_index),
      .rsp_best_score     (rsp_best_score),
      .rsp_index_overflow (rsp_index_overflow)
   );

endmodule

// File: rtl/core/nps_checker.sv
// ----------------------------------------------------------------------------
// Nearest pattern search port checker
// Watches the top-level ports for stall, range and reset behavior.
// ----------------------------------------------------------------------------
`include "nearest_pattern_search_top_macros.svh"

module nps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_best_index,
   input logic [16:0] rsp_best_score,
   input logic        rsp_index_overflow
);

   // A stalled result holds its value.
   `NPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_best_index) && $stable(rsp_best_score) && $stable(rsp_index_overflow), "stalled result changed")

   // A stalled result blocks new items.
   `NPS_ASSERT_IMPLY(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready, "item taken while result stalled")

   // A score never exceeds one.
   `NPS_ASSERT_IMPLY(a_score_range, clock, reset, rsp_valid, rsp_best_score <= 17'd65536, "score out of range")

   // No result right after reset.
   `NPS_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid, "result valid after reset")

endmodule

bind nearest_pattern_search_top nps_checker u_nps_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest pattern search testbench
// Loads a series of queries, streams candidate sets against each one and
// scores every candidate in a local tracker. The best index, score and
// overflow flag of each set are checked against every result item.
// ----------------------------------------------------------------------------
module tb_top;
   import nps_pkg::*;

   // Results trail the last candidate by three stages; allow some slack.
   localparam int PIPE_LATENCY  = 3;
   localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
   localparam int INDEX_MAX     = (1 << INDEX_BITS) - 1;
   localparam int RUN_LIMIT_NS  = 12_000_000;
   localparam int DEFAULT_IDLE  = 35;
   // Index 7 is not a register; a write to it must leave the query alone.
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [DIGIT_BITS*PATTERN_DIGITS-1:0] digits;
      logic [PHON_BITS*MAX_PHONEMES-1:0]    phon;
      logic [PCOUNT_BITS-1:0]               count;
      logic                                 last;
   } cand_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] index;
      logic [SCORE_BITS-1:0] score;
      logic                  overflow;
   } best_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [WORD_BITS-1:0]    req_cand_digits_a = '0;
   logic [WORD_BITS-1:0]    req_cand_digits_b = '0;
   logic [WORD_BITS-1:0]    req_cand_digits_c = '0;
   logic [WORD_BITS-1:0]    req_cand_digits_d = '0;
   logic [WORD_BITS-1:0]    req_cand_phon_lo = '0;
   logic [WORD_BITS-1:0]    req_cand_phon_hi = '0;
   logic [PCOUNT_BITS-1:0]  req_cand_phon_count = '0;
   logic                    req_last_candidate = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [INDEX_BITS-1:0]   rsp_best_index;
   logic [SCORE_BITS-1:0]   rsp_best_score;
   logic                    rsp_index_overflow;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [WORD_BITS-1:0]    csr_wdata = '0;

   // Candidates waiting to be driven, and set results still to come.
   cand_type pending_cands[$];
   best_type expected_best[$];

   int   req_idle_pct = DEFAULT_IDLE;
   int   rsp_idle_pct = DEFAULT_IDLE;
   logic req_taken = 1'b0;
   int   error_count = 0;

   // Query as the tracker sees it, updated on each register write.
   logic [DIGIT_BITS*PATTERN_DIGITS-1:0] trk_digits = '0;
   logic [PHON_BITS*MAX_PHONEMES-1:0]    trk_phon = '0;
   int                                   trk_count = 0;

   // Running best of the current set.
   logic [SCORE_BITS-1:0] best_score = '0;
   int                    best_pos = 0;
   int                    cand_index = 0;
   logic                  have_best = 1'b0;
   logic                  index_ovf = 1'b0;

   // Query as the stimulus side wrote it, used to build near matches.
   logic [DIGIT_BITS*PATTERN_DIGITS-1:0] stim_digits = '0;
   logic [PHON_BITS*MAX_PHONEMES-1:0]    stim_phon = '0;
   int                                   stim_count = 0;

   nearest_pattern_search_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cand_digits_a   (req_cand_digits_a),
      .req_cand_digits_b   (req_cand_digits_b),
      .req_cand_digits_c   (req_cand_digits_c),
      .req_cand_digits_d   (req_cand_digits_d),
      .req_cand_phon_lo    (req_cand_phon_lo),
      .req_cand_phon_hi    (req_cand_phon_hi),
      .req_cand_phon_count (req_cand_phon_count),
      .req_last_candidate  (req_last_candidate),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_best_index      (rsp_best_index),
      .rsp_best_score      (rsp_best_score),
      .rsp_index_overflow  (rsp_index_overflow),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------------
   // Tracker
   // ------------------------------------------------------------------------

   // Counts above the phoneme capacity behave as a full list.
   function automatic int clamp_count(logic [PCOUNT_BITS-1:0] c);
      return (c > MAX_PHONEMES) ? MAX_PHONEMES : int'(c);
   endfunction

   // Digit matches over all positions plus phoneme matches over the shorter
   // list, each term truncated on its own.
   function automatic logic [SCORE_BITS-1:0] similarity_score(cand_type c);
      int digit_hits;
      int phon_hits;
      int cand_len;
      int short_len;
      int long_len;
      int total;
      digit_hits = 0;
      phon_hits  = 0;
      cand_len   = clamp_count(c.count);
      short_len  = (cand_len < trk_count) ? cand_len : trk_count;
      long_len   = (cand_len > trk_count) ? cand_len : trk_count;
      for (int i = 0; i < PATTERN_DIGITS; i++)
         if (c.digits[DIGIT_BITS*i +: DIGIT_BITS] == trk_digits[DIGIT_BITS*i +: DIGIT_BITS])
            digit_hits++;
      for (int i = 0; i < short_len; i++)
         if (c.phon[PHON_BITS*i +: PHON_BITS] == trk_phon[PHON_BITS*i +: PHON_BITS])
            phon_hits++;
      total = (DIGIT_WEIGHT * digit_hits) / PATTERN_DIGITS;
      if (long_len != 0)
         total += (PHON_WEIGHT * phon_hits) / long_len;
      return total[SCORE_BITS-1:0];
   endfunction

   task automatic apply_register(logic [CSR_IDX_BITS-1:0] idx, logic [WORD_BITS-1:0] data);
      case (idx)
         CSR_DIGITS_A:   trk_digits[WORD_BITS*0 +: WORD_BITS] = data;
         CSR_DIGITS_B:   trk_digits[WORD_BITS*1 +: WORD_BITS] = data;
         CSR_DIGITS_C:   trk_digits[WORD_BITS*2 +: WORD_BITS] = data;
         CSR_DIGITS_D:   trk_digits[WORD_BITS*3 +: WORD_BITS] = data;
         CSR_PHON_LO:    trk_phon[WORD_BITS*0 +: WORD_BITS] = data;
         CSR_PHON_HI:    trk_phon[WORD_BITS*1 +: WORD_BITS] = data;
         CSR_PHON_COUNT: trk_count = clamp_count(data[PCOUNT_BITS-1:0]);
         default: ;
      endcase
   endtask

   // Score one accepted candidate; on the last one of a set, queue the
   // set's result and start over.
   task automatic track_candidate(cand_type c);
      logic [SCORE_BITS-1:0] s;
      int                    idx;
      best_type              b;
      s   = similarity_score(c);
      idx = have_best ? cand_index + 1 : 0;
      if (idx > INDEX_MAX) begin
         idx       = INDEX_MAX;
         index_ovf = 1'b1;
      end
      cand_index = idx;
      // First of a set always wins; later ones only on a strictly higher score.
      if (!have_best || s > best_score) begin
         best_score = s;
         best_pos   = idx;
      end
      have_best = 1'b1;
      if (c.last) begin
         b.index    = best_pos[INDEX_BITS-1:0];
         b.score    = best_score;
         b.overflow = index_ovf;
         expected_best.push_back(b);
         best_score = '0;
         best_pos   = 0;
         cand_index = 0;
         have_best  = 1'b0;
         index_ovf  = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: change inputs on the falling edge only.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      cand_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // Hold valid and payload until taken; otherwise idle or advance.
         if (pending_cands.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            c = pending_cands.pop_front();
            req_valid           <= 1'b1;
            req_cand_digits_a   <= c.digits[WORD_BITS*0 +: WORD_BITS];
            req_cand_digits_b   <= c.digits[WORD_BITS*1 +: WORD_BITS];
            req_cand_digits_c   <= c.digits[WORD_BITS*2 +: WORD_BITS];
            req_cand_digits_d   <= c.digits[WORD_BITS*3 +: WORD_BITS];
            req_cand_phon_lo    <= c.phon[WORD_BITS*0 +: WORD_BITS];
            req_cand_phon_hi    <= c.phon[WORD_BITS*1 +: WORD_BITS];
            req_cand_phon_count <= c.count;
            req_last_candidate  <= c.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // ------------------------------------------------------------------------
   // Monitor: sample handshakes on the rising edge, predict and check.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cand_type seen;
      best_type got;
      best_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (csr_wr_en)
            apply_register(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            req_taken    = 1'b1;
            seen.digits  = {req_cand_digits_d, req_cand_digits_c,
                            req_cand_digits_b, req_cand_digits_a};
            seen.phon    = {req_cand_phon_hi, req_cand_phon_lo};
            seen.count   = req_cand_phon_count;
            seen.last    = req_last_candidate;
            track_candidate(seen);
         end
         if (rsp_valid && rsp_ready) begin
            got.index    = rsp_best_index;
            got.score    = rsp_best_score;
            got.overflow = rsp_index_overflow;
            if (expected_best.size() == 0) begin
               $error("result item with no set pending: index %0d score %0d",
                      got.index, got.score);
               error_count++;
            end else begin
               want = expected_best.pop_front();
               if (got.index !== want.index) begin
                  $error("best_index: expected %0d, actual %0d", want.index, got.index);
                  error_count++;
               end
               if (got.score !== want.score) begin
                  $error("best_score: expected %0d, actual %0d", want.score, got.score);
                  error_count++;
               end
               if (got.overflow !== want.overflow) begin
                  $error("index_overflow: expected %0d, actual %0d",
                         want.overflow, got.overflow);
                  error_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic logic [WORD_BITS-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Write one register; only call while the block is idle.
   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [WORD_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_DIGITS_A:   stim_digits[WORD_BITS*0 +: WORD_BITS] = data;
         CSR_DIGITS_B:   stim_digits[WORD_BITS*1 +: WORD_BITS] = data;
         CSR_DIGITS_C:   stim_digits[WORD_BITS*2 +: WORD_BITS] = data;
         CSR_DIGITS_D:   stim_digits[WORD_BITS*3 +: WORD_BITS] = data;
         CSR_PHON_LO:    stim_phon[WORD_BITS*0 +: WORD_BITS] = data;
         CSR_PHON_HI:    stim_phon[WORD_BITS*1 +: WORD_BITS] = data;
         CSR_PHON_COUNT: stim_count = clamp_count(data[PCOUNT_BITS-1:0]);
         default: ;
      endcase
   endtask

   task automatic load_query(logic [DIGIT_BITS*PATTERN_DIGITS-1:0] digits,
                             logic [PHON_BITS*MAX_PHONEMES-1:0] phon,
                             logic [WORD_BITS-1:0] count_word);
      write_reg(CSR_DIGITS_A, digits[WORD_BITS*0 +: WORD_BITS]);
      write_reg(CSR_DIGITS_B, digits[WORD_BITS*1 +: WORD_BITS]);
      write_reg(CSR_DIGITS_C, digits[WORD_BITS*2 +: WORD_BITS]);
      write_reg(CSR_DIGITS_D, digits[WORD_BITS*3 +: WORD_BITS]);
      write_reg(CSR_PHON_LO, phon[WORD_BITS*0 +: WORD_BITS]);
      write_reg(CSR_PHON_HI, phon[WORD_BITS*1 +: WORD_BITS]);
      write_reg(CSR_PHON_COUNT, count_word);
   endtask

   // Candidate that copies each query digit or phoneme with the given odds
   // and draws the rest at random.
   function automatic cand_type near_cand(int digit_pct, int phon_pct);
      cand_type c;
      int       r;
      for (int i = 0; i < PATTERN_DIGITS; i++)
         c.digits[DIGIT_BITS*i +: DIGIT_BITS] = ($urandom_range(0, 99) < digit_pct) ?
            stim_digits[DIGIT_BITS*i +: DIGIT_BITS] : DIGIT_BITS'($urandom);
      for (int i = 0; i < MAX_PHONEMES; i++)
         c.phon[PHON_BITS*i +: PHON_BITS] = ($urandom_range(0, 99) < phon_pct) ?
            stim_phon[PHON_BITS*i +: PHON_BITS] : PHON_BITS'($urandom);
      r = $urandom_range(0, 99);
      if (r < 60)
         c.count = PCOUNT_BITS'(stim_count);
      else if (r < 90)
         c.count = PCOUNT_BITS'($urandom_range(0, MAX_PHONEMES));
      else
         c.count = PCOUNT_BITS'($urandom_range(MAX_PHONEMES + 1, (1 << PCOUNT_BITS) - 1));
      c.last = 1'b0;
      return c;
   endfunction

   function automatic cand_type exact_cand();
      cand_type c;
      c       = near_cand(100, 100);
      c.count = PCOUNT_BITS'(stim_count);
      return c;
   endfunction

   // Queue whole sets, mostly short, with repeats of earlier members to
   // force ties and some pure noise.
   task automatic queue_sets(int total);
      cand_type set_items[$];
      cand_type c;
      int       len;
      int       r;
      int       queued;
      queued = 0;
      while (queued < total) begin
         r = $urandom_range(0, 99);
         if (r < 75)
            len = $urandom_range(1, 8);
         else if (r < 95)
            len = $urandom_range(9, 30);
         else
            len = $urandom_range(31, 60);
         set_items.delete();
         for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (set_items.size() != 0 && r < 15)
               c = set_items[$urandom_range(0, set_items.size() - 1)];
            else if (r < 25)
               c = near_cand(0, 0);
            else if (r < 30)
               c = exact_cand();
            else
               c = near_cand($urandom_range(0, 100), $urandom_range(0, 100));
            c.last = (k == len - 1);
            set_items.push_back(c);
            pending_cands.push_back(c);
         end
         queued += len;
      end
   endtask

   // Pause the sender until every queued candidate is taken and every set
   // result has come back, then let the pipeline drain.
   task automatic wait_idle();
      while (pending_cands.size() != 0 || req_valid || expected_best.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      cand_type             c;
      logic [WORD_BITS-1:0] count_word;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Reset query: all-zero digits, no phonemes.
      c      = '0;
      c.last = 1'b1;
      pending_cands.push_back(c);                  // every digit matches
      c.digits = '1;
      c.phon   = '1;
      c.count  = '1;                               // count above capacity
      pending_cands.push_back(c);                  // nothing matches
      c       = '0;
      c.phon  = '1;
      c.count = PCOUNT_BITS'(MAX_PHONEMES);
      pending_cands.push_back(c);
      c      = '0;
      c.last = 1'b1;
      pending_cands.push_back(c);                  // tie keeps the first
      wait_idle();

      // Random query with a full phoneme list; junk in the upper count bits.
      count_word = rand_word();
      count_word[PCOUNT_BITS-1:0] = PCOUNT_BITS'(MAX_PHONEMES);
      load_query({rand_word(), rand_word(), rand_word(), rand_word()},
                 {rand_word(), rand_word()}, count_word);
      pending_cands.push_back(near_cand(20, 20));
      c = exact_cand();
      pending_cands.push_back(c);                  // full score
      pending_cands.push_back(c);                  // equal score must not win
      c.digits = ~stim_digits;
      c.phon   = ~stim_phon;
      c.last   = 1'b1;
      pending_cands.push_back(c);
      c       = exact_cand();
      c.count = PCOUNT_BITS'(20);                  // clamps to a full list
      c.last  = 1'b1;
      pending_cands.push_back(c);
      c.count = '0;                                // no candidate phonemes
      pending_cands.push_back(c);
      wait_idle();

      // Write to the unused index, then an oversized phoneme count.
      write_reg(CSR_UNUSED, rand_word());
      write_reg(CSR_PHON_COUNT, WORD_BITS'((1 << PCOUNT_BITS) - 1));
      c      = exact_cand();
      c.last = 1'b1;
      pending_cands.push_back(c);
      wait_idle();

      // Empty query phoneme list: no phoneme can match, so the phonetic term is zero.
      write_reg(CSR_PHON_COUNT, '0);
      c       = exact_cand();
      c.count = PCOUNT_BITS'(5);
      pending_cands.push_back(c);
      c.count = '0;
      c.last  = 1'b1;
      pending_cands.push_back(c);
      wait_idle();

      // Short query list against a longer candidate list.
      write_reg(CSR_PHON_COUNT, WORD_BITS'(3));
      c       = exact_cand();
      c.count = PCOUNT_BITS'(10);
      c.last  = 1'b1;
      pending_cands.push_back(c);
      wait_idle();

      // Random sets under a random query.
      load_query({rand_word(), rand_word(), rand_word(), rand_word()},
                 {rand_word(), rand_word()}, WORD_BITS'(MAX_PHONEMES));
      queue_sets(140);
      wait_idle();

      // All-zero query.
      load_query('0, '0, '0);
      queue_sets(120);
      wait_idle();

      // All-ones query, no idling on either side for this stretch.
      load_query('1, '1, '1);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      queue_sets(120);
      wait_idle();
      req_idle_pct = DEFAULT_IDLE;
      rsp_idle_pct = DEFAULT_IDLE;

      // Partial phoneme lists.
      load_query({rand_word(), rand_word(), rand_word(), rand_word()},
                 {rand_word(), rand_word()}, WORD_BITS'($urandom_range(1, MAX_PHONEMES - 1)));
      queue_sets(140);
      wait_idle();

      // Fully random count word.
      load_query({rand_word(), rand_word(), rand_word(), rand_word()},
                 {rand_word(), rand_word()}, rand_word());
      queue_sets(150);
      wait_idle();

      // More random sets under a fresh query.
      load_query({rand_word(), rand_word(), rand_word(), rand_word()},
                 {rand_word(), rand_word()}, rand_word());
      queue_sets(130);
      wait_idle();

      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   // Stop a hung run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("tb_top: errors");
      $finish;
   end

endmodule

// File: nearest_pattern_search_top.f
+incdir+rtl/core
rtl/core/nps_pkg.sv
rtl/core/nps_digit_lane.sv
rtl/core/nps_phon_lane.sv
rtl/core/nps_merge.sv
rtl/core/nearest_pattern_search_top.sv
rtl/core/nps_checker.sv
tb/tb_top.sv
